@@ rtl/bdalloc_pkg.sv @@
// bdalloc_pkg: shared constants, command and state codes, control structs
`default_nettype none

package bdalloc_pkg;

	localparam int NUM_IDS_DEF      = 16;
	localparam int NUM_CHANNELS_DEF = 4;
	localparam int NUM_REGS         = 4;
	localparam int MASK_W           = 16;
	localparam int CMD_W            = 2;
	localparam int CHAN_W           = 2;
	localparam int CNT_W            = 5;
	localparam int BD_ID_W          = 4;
	localparam int CFG_IDX_W        = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SMALLEST = 2'd0,
		CMD_INCR     = 2'd1,
		CMD_RUN      = 2'd2
	} bdalloc_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} bdalloc_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} bdalloc_ctl_t;

	typedef struct packed {
		logic scan_end;
		logic out_free;
		logic emit_last;
	} bdalloc_stat_t;

endpackage

`default_nettype wire

@@ rtl/bdalloc_ifs.sv @@
// bdalloc_ifs: request, result and configuration channel interfaces
`default_nettype none

interface bdalloc_req_if import bdalloc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CHAN_W-1:0] channel;
	logic [CNT_W-1:0]  count;

	modport source (output valid, command, channel, count, input ready);
	modport sink   (input valid, command, channel, count, output ready);
endinterface

interface bdalloc_rsp_if import bdalloc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic [BD_ID_W-1:0] bd_id;
	logic               last;

	modport source (output valid, found, bd_id, last, input ready);
	modport sink   (input valid, found, bd_id, last, output ready);
endinterface

interface bdalloc_cfg_if import bdalloc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [MASK_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/channel_bd_id_allocator.sv @@
// channel_bd_id_allocator: per-channel descriptor id allocator, top level
// the first result enters the output register after the id scan, which visits one id per cycle
// over min(NUM_IDS,16) ids; results then follow one a cycle unless the output is held
// n results (1..16) per request; a new request waits until the last result is emitted
// the next request is taken while the final result still waits in the output register
// reset: masks, assigned bitmap and last assigned id cleared, no result pending
`default_nettype none

module channel_bd_id_allocator import bdalloc_pkg::*; #(
	parameter int NUM_IDS      = NUM_IDS_DEF,
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bdalloc_req_if.sink   req,
	bdalloc_rsp_if.source rsp,
	bdalloc_cfg_if.sink   cfg
);

	bdalloc_ctl_t  ctl;
	bdalloc_stat_t stat;

	assign cfg.ready = 1'b1;

	bdalloc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	bdalloc_dp #(
		.NUM_IDS      (NUM_IDS),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.req_command (req.command),
		.req_channel (req.channel),
		.req_count   (req.count),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_found   (rsp.found),
		.rsp_bd_id   (rsp.bd_id),
		.rsp_last    (rsp.last)
	);

endmodule

`default_nettype wire

@@ rtl/bdalloc_ctrl.sv @@
// bdalloc_ctrl: request sequencer, idle / scan / emit state machine
`default_nettype none

module bdalloc_ctrl import bdalloc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bdalloc_stat_t stat,
	output bdalloc_ctl_t  ctl
);

	bdalloc_state_t state_q;
	bdalloc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free && stat.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		ctl       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				ctl.load  = req_valid;
			end
			ST_SCAN: begin
				ctl.step = 1'b1;
			end
			ST_EMIT: begin
				ctl.emit = stat.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/bdalloc_dp.sv @@
// bdalloc_dp: masks, assigned bitmap, id scan and result register
`default_nettype none

module bdalloc_dp import bdalloc_pkg::*; #(
	parameter int NUM_IDS      = NUM_IDS_DEF,
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdalloc_ctl_t         ctl,
	output bdalloc_stat_t        stat,
	input  logic [CMD_W-1:0]     req_command,
	input  logic [CHAN_W-1:0]    req_channel,
	input  logic [CNT_W-1:0]     req_count,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MASK_W-1:0]    cfg_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic                 rsp_found,
	output logic [BD_ID_W-1:0]   rsp_bd_id,
	output logic                 rsp_last
);

	localparam int SCAN_N = (NUM_IDS < MASK_W) ? NUM_IDS : MASK_W;
	localparam int IDX_W  = $clog2(SCAN_N);
	localparam int LEN_W  = $clog2(SCAN_N + 1);

	logic [MASK_W-1:0]  mask_q [NUM_REGS];
	logic [SCAN_N-1:0]  assigned_map_q;
	logic [BD_ID_W-1:0] last_assigned_q;

	bdalloc_cmd_t       cmd_q;
	logic [CNT_W-1:0]   count_q;
	logic [SCAN_N-1:0]  avail_q;
	logic [IDX_W-1:0]   idx_q;
	logic               any_v_q;
	logic [IDX_W-1:0]   any_id_q;
	logic               abv_v_q;
	logic [IDX_W-1:0]   abv_id_q;
	logic [LEN_W-1:0]   cur_len_q;
	logic [IDX_W-1:0]   cur_start_q;
	logic [LEN_W-1:0]   best_len_q;
	logic [IDX_W-1:0]   best_start_q;
	logic               stop_q;
	logic [CNT_W-1:0]   k_q;

	logic               rsp_valid_q;
	logic               rsp_found_q;
	logic [BD_ID_W-1:0] rsp_id_q;
	logic               rsp_last_q;

	logic [MASK_W-1:0]  chan_mask;
	logic               chan_ok;
	logic [SCAN_N-1:0]  avail_d;
	logic               scan_bit;
	logic               above;

	logic [IDX_W-1:0]   run_start;
	logic [LEN_W-1:0]   len_inc;
	logic [LEN_W-1:0]   cur_len_d;
	logic [IDX_W-1:0]   cur_start_d;
	logic [LEN_W-1:0]   best_len_d;
	logic [IDX_W-1:0]   best_start_d;
	logic               stop_d;

	logic [CNT_W-1:0]   best_cnt;
	logic [CNT_W-1:0]   run_n;
	logic               sel_found;
	logic [IDX_W-1:0]   sel_start;
	logic [CNT_W-1:0]   sel_n;
	logic [CNT_W-1:0]   emit_n;
	logic [IDX_W-1:0]   emit_idx;
	logic               emit_last;

	// channel mask and free ids at request transfer
	assign chan_mask = mask_q[req_channel];
	assign chan_ok   = 32'(req_channel) < NUM_CHANNELS;
	assign avail_d   = chan_ok ? (chan_mask[SCAN_N-1:0] & ~assigned_map_q) : '0;

	assign scan_bit = avail_q[idx_q];
	assign above    = BD_ID_W'(idx_q) > last_assigned_q;

	// run tracking for the consecutive command
	always_comb begin
		run_start    = (cur_len_q == '0) ? idx_q : cur_start_q;
		len_inc      = cur_len_q + LEN_W'(1);
		cur_len_d    = cur_len_q;
		cur_start_d  = cur_start_q;
		best_len_d   = best_len_q;
		best_start_d = best_start_q;
		stop_d       = stop_q;
		if (!stop_q) begin
			if (scan_bit) begin
				cur_len_d   = len_inc;
				cur_start_d = run_start;
				if (len_inc > best_len_q) begin
					best_len_d   = len_inc;
					best_start_d = run_start;
				end
				stop_d = CNT_W'(best_len_d) >= count_q;
			end else begin
				cur_len_d = '0;
			end
		end
	end

	// result selection
	assign best_cnt = CNT_W'(best_len_q);
	assign run_n    = (best_cnt < count_q) ? best_cnt : count_q;

	always_comb begin
		sel_found = 1'b0;
		sel_start = '0;
		sel_n     = CNT_W'(1);
		case (cmd_q)
			CMD_SMALLEST: begin
				sel_found = any_v_q;
				sel_start = any_id_q;
			end
			CMD_INCR: begin
				sel_found = any_v_q;
				sel_start = abv_v_q ? abv_id_q : any_id_q;
			end
			CMD_RUN: begin
				sel_found = run_n != '0;
				sel_start = best_start_q;
				sel_n     = run_n;
			end
			default: begin
				sel_found = 1'b0;
			end
		endcase
	end

	assign emit_n    = sel_found ? sel_n : CNT_W'(1);
	assign emit_idx  = IDX_W'(CNT_W'(sel_start) + k_q);
	assign emit_last = (k_q + CNT_W'(1)) == emit_n;

	assign stat.scan_end  = idx_q == IDX_W'(SCAN_N - 1);
	assign stat.out_free  = !rsp_valid_q || rsp_ready;
	assign stat.emit_last = emit_last;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				mask_q[r] <= '0;
			end
		end else if (cfg_we) begin
			mask_q[cfg_index] <= cfg_data;
		end
	end

	// allocation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assigned_map_q  <= '0;
			last_assigned_q <= '0;
		end else if (ctl.emit && sel_found) begin
			assigned_map_q[emit_idx] <= 1'b1;
			last_assigned_q          <= BD_ID_W'(emit_idx);
		end
	end

	// scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q        <= CMD_SMALLEST;
			count_q      <= '0;
			avail_q      <= '0;
			idx_q        <= '0;
			any_v_q      <= 1'b0;
			any_id_q     <= '0;
			abv_v_q      <= 1'b0;
			abv_id_q     <= '0;
			cur_len_q    <= '0;
			cur_start_q  <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			stop_q       <= 1'b0;
			k_q          <= '0;
		end else begin
			if (ctl.load) begin
				cmd_q        <= bdalloc_cmd_t'(req_command);
				count_q      <= req_count;
				avail_q      <= avail_d;
				idx_q        <= '0;
				any_v_q      <= 1'b0;
				abv_v_q      <= 1'b0;
				cur_len_q    <= '0;
				best_len_q   <= '0;
				best_start_q <= '0;
				stop_q       <= 1'b0;
				k_q          <= '0;
			end else if (ctl.step) begin
				idx_q        <= idx_q + IDX_W'(1);
				cur_len_q    <= cur_len_d;
				cur_start_q  <= cur_start_d;
				best_len_q   <= best_len_d;
				best_start_q <= best_start_d;
				stop_q       <= stop_d;
				if (scan_bit && !any_v_q) begin
					any_v_q  <= 1'b1;
					any_id_q <= idx_q;
				end
				if (scan_bit && above && !abv_v_q) begin
					abv_v_q  <= 1'b1;
					abv_id_q <= idx_q;
				end
			end
			if (ctl.emit) begin
				k_q <= k_q + CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			rsp_found_q <= sel_found;
			rsp_id_q    <= sel_found ? BD_ID_W'(emit_idx) : '0;
			rsp_last_q  <= emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_found = rsp_found_q;
	assign rsp_bd_id = rsp_id_q;
	assign rsp_last  = rsp_last_q;

	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten before transfer");

	a_emit_free_id: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && sel_found) |-> !assigned_map_q[emit_idx])
		else $error("id assigned twice");

	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && sel_found) |=> last_assigned_q == $past(BD_ID_W'(emit_idx)))
		else $error("last assigned id not updated");

	a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !(ctl.load || ctl.step))
		else $error("emit overlaps load or scan step");

endmodule

`default_nettype wire
